// ----- rtl/leb_pkg.sv -----
`default_nettype none

package leb_pkg;

    // Line geometry
    localparam int LINE_MAX = 256;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int POS_W    = 9;
    localparam int CNT_W    = 16;

    // Request codes
    localparam logic [2:0] REQ_LEFT   = 3'd0;
    localparam logic [2:0] REQ_RIGHT  = 3'd1;
    localparam logic [2:0] REQ_BKSPC  = 3'd2;
    localparam logic [2:0] REQ_DEL    = 3'd3;
    localparam logic [2:0] REQ_INSERT = 3'd4;
    localparam logic [2:0] REQ_READ   = 3'd5;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] char_in;
        logic [7:0] read_index;
    } req_t;

    typedef struct packed {
        logic             applied;
        logic [POS_W-1:0] cursor_pos;
        logic [POS_W-1:0] line_len;
        logic             dirty_flag;
        logic [CNT_W-1:0] delete_total;
        logic [7:0]       read_byte;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/leb_if.sv -----
`default_nettype none

// Request channel
interface leb_req_if;
    logic          valid;
    logic          ready;
    leb_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface leb_rsp_if;
    logic          valid;
    logic          ready;
    leb_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/line_edit_buffer.sv -----
`default_nettype none

// Channel  Dir  Handshake      Payload
// req      in   valid/ready    req_type, char_in, read_index
// rsp      out  valid/ready    applied, cursor_pos, line_len, dirty_flag,
//                              delete_total, read_byte
//
// Moves, refusals and reads past the line end go straight to the result state;
// a read inside it passes the RAM read state first. Insert and erase move one
// stored byte per cycle through the line RAM before the result state.
// Next request is taken once the previous result sits in the output register.
// rst_n clears cursor, length, dirty mark and delete count; the RAM is not cleared.
// A stalled result holds in the output register; a finished item waits for it.
module line_edit_buffer (
    input  wire logic clk,
    input  wire logic rst_n,
    leb_req_if.sink   req,
    leb_rsp_if.source rsp
);

    localparam int AW = leb_pkg::ADDR_W;
    localparam int LW = leb_pkg::LEN_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]                 state_reg;
    logic [LW-1:0]              cursor_reg;
    logic [LW-1:0]              length_reg;
    logic                       dirty_reg;
    logic [leb_pkg::CNT_W-1:0]  del_cnt_reg;

    // per-item working registers
    logic                       ok_reg;
    logic [7:0]                 rd_reg;
    logic [7:0]                 ch_reg;
    logic                       up_reg;
    logic [LW-1:0]              src_reg;
    logic [LW-1:0]              bound_reg;
    logic                       pend_valid_reg;
    logic [AW-1:0]              pend_addr_reg;

    logic                       out_valid_reg;
    leb_pkg::rsp_t              out_data_reg;

    // RAM port signals
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [7:0]                 ram_rdata;

    logic                       in_fire;
    logic                       issue;
    logic                       shift_done;
    logic                       out_free;
    logic [AW-1:0]              shift_raddr;
    logic [AW-1:0]              shift_waddr;
    logic [1:0]                 fire_state;

    assign req.ready = (state_reg == ST_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Shift sequencing: read one byte, write it one place over next cycle
    always_comb
    begin
        if (up_reg)
        begin
            issue       = (src_reg > bound_reg);
            shift_raddr = AW'(src_reg - LW'(1));
            shift_waddr = AW'(src_reg);
        end
        else
        begin
            issue       = (src_reg < bound_reg);
            shift_raddr = AW'(src_reg);
            shift_waddr = AW'(src_reg - LW'(1));
        end
        if (state_reg != ST_SHIFT)
        begin
            issue = 1'b0;
        end
        shift_done = (state_reg == ST_SHIFT) && !issue && !pend_valid_reg;
    end

    // State entered by an accepted request
    always_comb
    begin
        fire_state = ST_RESP;
        case (req.data.req_type)
            leb_pkg::REQ_BKSPC:
            begin
                if (cursor_reg != '0)
                begin
                    fire_state = ST_SHIFT;
                end
            end
            leb_pkg::REQ_DEL:
            begin
                if (cursor_reg < length_reg)
                begin
                    fire_state = ST_SHIFT;
                end
            end
            leb_pkg::REQ_INSERT:
            begin
                if (length_reg < LW'(leb_pkg::LINE_MAX))
                begin
                    fire_state = ST_SHIFT;
                end
            end
            leb_pkg::REQ_READ:
            begin
                if ({{(LW-8){1'b0}}, req.data.read_index} < length_reg)
                begin
                    fire_state = ST_READ;
                end
            end
            default:
            begin
            end
        endcase
    end

    // RAM access selection
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = shift_raddr;
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        if (in_fire && (req.data.req_type == leb_pkg::REQ_READ))
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(req.data.read_index);
        end
        else if (issue)
        begin
            ram_re = 1'b1;
        end
        if (pend_valid_reg)
        begin
            ram_we = 1'b1;
        end
        else if (shift_done && up_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(bound_reg);
            ram_wdata = ch_reg;
        end
    end

    leb_ram #(
        .WIDTH (8),
        .DEPTH (leb_pkg::LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            length_reg     <= '0;
            dirty_reg      <= 1'b0;
            del_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // output register: loads on leaving ST_RESP, clears when taken
            if ((state_reg == ST_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= fire_state;
                        case (req.data.req_type)
                            leb_pkg::REQ_LEFT:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_reg <= cursor_reg - LW'(1);
                                end
                            end
                            leb_pkg::REQ_RIGHT:
                            begin
                                if (cursor_reg < length_reg)
                                begin
                                    cursor_reg <= cursor_reg + LW'(1);
                                end
                            end
                            leb_pkg::REQ_BKSPC:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_reg <= cursor_reg - LW'(1);
                                    length_reg <= length_reg - LW'(1);
                                    dirty_reg  <= 1'b1;
                                    if (del_cnt_reg != '1)
                                    begin
                                        del_cnt_reg <= del_cnt_reg + leb_pkg::CNT_W'(1);
                                    end
                                end
                            end
                            leb_pkg::REQ_DEL:
                            begin
                                if (cursor_reg < length_reg)
                                begin
                                    length_reg <= length_reg - LW'(1);
                                    dirty_reg  <= 1'b1;
                                    if (del_cnt_reg != '1)
                                    begin
                                        del_cnt_reg <= del_cnt_reg + leb_pkg::CNT_W'(1);
                                    end
                                end
                            end
                            leb_pkg::REQ_INSERT:
                            begin
                                if (length_reg < LW'(leb_pkg::LINE_MAX))
                                begin
                                    cursor_reg <= cursor_reg + LW'(1);
                                    length_reg <= length_reg + LW'(1);
                                    dirty_reg  <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SHIFT:
                begin
                    pend_valid_reg <= issue;
                    if (shift_done)
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Per-item datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg <= req.data.char_in;
            rd_reg <= 8'd0;
            case (req.data.req_type)
                leb_pkg::REQ_LEFT:
                begin
                    ok_reg <= (cursor_reg != '0);
                end
                leb_pkg::REQ_RIGHT:
                begin
                    ok_reg <= (cursor_reg < length_reg);
                end
                leb_pkg::REQ_BKSPC:
                begin
                    ok_reg    <= (cursor_reg != '0);
                    up_reg    <= 1'b0;
                    src_reg   <= cursor_reg;
                    bound_reg <= length_reg;
                end
                leb_pkg::REQ_DEL:
                begin
                    ok_reg    <= (cursor_reg < length_reg);
                    up_reg    <= 1'b0;
                    src_reg   <= cursor_reg + LW'(1);
                    bound_reg <= length_reg;
                end
                leb_pkg::REQ_INSERT:
                begin
                    ok_reg    <= (length_reg < LW'(leb_pkg::LINE_MAX));
                    up_reg    <= 1'b1;
                    src_reg   <= length_reg;
                    bound_reg <= cursor_reg;
                end
                default:
                begin
                    ok_reg <= 1'b0;
                end
            endcase
        end
        if (issue)
        begin
            src_reg       <= up_reg ? (src_reg - LW'(1)) : (src_reg + LW'(1));
            pend_addr_reg <= shift_waddr;
        end
        if (state_reg == ST_READ)
        begin
            rd_reg <= ram_rdata;
        end
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_data_reg.applied      <= ok_reg;
            out_data_reg.cursor_pos   <= leb_pkg::POS_W'(cursor_reg);
            out_data_reg.line_len     <= leb_pkg::POS_W'(length_reg);
            out_data_reg.dirty_flag   <= dirty_reg;
            out_data_reg.delete_total <= del_cnt_reg;
            out_data_reg.read_byte    <= rd_reg;
        end
    end

    // Checks
    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= length_reg)
        else $error("cursor beyond line end");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(leb_pkg::LINE_MAX))
        else $error("line length beyond capacity");

    a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SHIFT))
        else $error("shift write pending outside shift");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !ram_we)
        else $error("RAM write during byte read");

endmodule

`default_nettype wire

// ----- rtl/leb_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // Request codes the block ignores
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam int CNT_FULL     = 65535;
    localparam int STALL_PCT    = 24;
    localparam int DRAIN_LIMIT  = 5000;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_WANDER} edit_mix_t;

    logic clk;
    logic rst_n;

    leb_req_if req_ch ();
    leb_rsp_if rsp_ch ();

    line_edit_buffer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the line: bytes, cursor, length, dirty mark, delete count
    logic [7:0]  line_img [leb_pkg::LINE_MAX];
    int unsigned cur_pos;
    int unsigned line_length;
    bit          dirty_mark;
    int unsigned delete_cnt;

    leb_pkg::rsp_t pending_rsp [$];
    int            err_count;
    bit            idle_en;
    int            rsp_hold;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Apply one request to the shadow line and return the result it gives
    function automatic leb_pkg::rsp_t predict_edit(leb_pkg::req_t r);
        leb_pkg::rsp_t o;
        int unsigned   i;
        o = '0;
        case (r.req_type)
            leb_pkg::REQ_LEFT:
                if (cur_pos > 0)
                begin
                    cur_pos--;
                    o.applied = 1'b1;
                end
            leb_pkg::REQ_RIGHT:
                if (cur_pos < line_length)
                begin
                    cur_pos++;
                    o.applied = 1'b1;
                end
            leb_pkg::REQ_BKSPC, leb_pkg::REQ_DEL:
                if ((r.req_type == leb_pkg::REQ_BKSPC) ? (cur_pos > 0)
                                                       : (cur_pos < line_length))
                begin
                    if (r.req_type == leb_pkg::REQ_BKSPC)
                        cur_pos--;
                    // close the gap at the cursor
                    for (i = cur_pos; i + 1 < line_length; i++)
                        line_img[i] = line_img[i + 1];
                    line_length--;
                    dirty_mark = 1'b1;
                    if (delete_cnt < CNT_FULL)
                        delete_cnt++;
                    o.applied = 1'b1;
                end
            leb_pkg::REQ_INSERT:
                if (line_length < leb_pkg::LINE_MAX)
                begin
                    for (i = line_length; i > cur_pos; i--)
                        line_img[i] = line_img[i - 1];
                    line_img[cur_pos] = r.char_in;
                    line_length++;
                    cur_pos++;
                    dirty_mark = 1'b1;
                    o.applied = 1'b1;
                end
            leb_pkg::REQ_READ:
                if (r.read_index < line_length)
                    o.read_byte = line_img[r.read_index];
            default: ;
        endcase
        o.cursor_pos   = leb_pkg::POS_W'(cur_pos);
        o.line_len     = leb_pkg::POS_W'(line_length);
        o.dirty_flag   = dirty_mark;
        o.delete_total = leb_pkg::CNT_W'(delete_cnt);
        return o;
    endfunction

    // Offer one item; log its expected result once accepted
    task automatic send_req(input logic [2:0] kind, input logic [7:0] ch,
                            input logic [7:0] idx);
        leb_pkg::req_t item;
        item.req_type   = kind;
        item.char_in    = ch;
        item.read_index = idx;
        @(negedge clk);
        while (idle_en && $urandom_range(99) < STALL_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_rsp.push_back(predict_edit(item));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_rsp.size() > 0)
        begin
            $error("%0d results never arrived", pending_rsp.size());
            err_count += pending_rsp.size();
            pending_rsp.delete();
        end
    endtask

    // Random request shaped by the current edit mix
    task automatic send_random(input edit_mix_t mix);
        int         roll;
        logic [2:0] kind;
        logic [7:0] idx;
        roll = $urandom_range(99);
        case (mix)
            MIX_GROW:
                kind = (roll < 55) ? leb_pkg::REQ_INSERT :
                       (roll < 65) ? leb_pkg::REQ_LEFT :
                       (roll < 75) ? leb_pkg::REQ_RIGHT :
                       (roll < 80) ? leb_pkg::REQ_BKSPC :
                       (roll < 85) ? leb_pkg::REQ_DEL :
                       (roll < 97) ? leb_pkg::REQ_READ : REQ_SPARE_A;
            MIX_SHRINK:
                kind = (roll < 15) ? leb_pkg::REQ_INSERT :
                       (roll < 25) ? leb_pkg::REQ_LEFT :
                       (roll < 35) ? leb_pkg::REQ_RIGHT :
                       (roll < 60) ? leb_pkg::REQ_BKSPC :
                       (roll < 85) ? leb_pkg::REQ_DEL :
                       (roll < 97) ? leb_pkg::REQ_READ : REQ_SPARE_B;
            default:
                kind = (roll < 20) ? leb_pkg::REQ_INSERT :
                       (roll < 40) ? leb_pkg::REQ_LEFT :
                       (roll < 60) ? leb_pkg::REQ_RIGHT :
                       (roll < 67) ? leb_pkg::REQ_BKSPC :
                       (roll < 74) ? leb_pkg::REQ_DEL :
                       (roll < 97) ? leb_pkg::REQ_READ : REQ_SPARE_A;
        endcase
        // reads mostly land inside the line
        if (line_length > 0 && $urandom_range(99) < 80)
            idx = 8'($urandom_range(line_length - 1));
        else
            idx = 8'($urandom_range(255));
        send_req(kind, 8'($urandom_range(255)), idx);
    endtask

    // Result sink: random stalls plus counted hold-offs
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(99) < STALL_PCT)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        leb_pkg::rsp_t got;
        leb_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0)
            begin
                err_count++;
                $error("result with no request outstanding");
            end
            else
            begin
                want = pending_rsp.pop_front();
                compare_field("applied", 16'(want.applied), 16'(got.applied));
                compare_field("cursor_pos", 16'(want.cursor_pos), 16'(got.cursor_pos));
                compare_field("line_len", 16'(want.line_len), 16'(got.line_len));
                compare_field("dirty_flag", 16'(want.dirty_flag), 16'(got.dirty_flag));
                compare_field("delete_total", want.delete_total, got.delete_total);
                compare_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
            end
        end
    end

    // Refusals on an empty line, ignored codes, then small edits
    task automatic test_directed();
        send_req(leb_pkg::REQ_LEFT, 8'hFF, 8'hFF);
        send_req(leb_pkg::REQ_RIGHT, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_BKSPC, 8'hFF, 8'hFF);
        send_req(leb_pkg::REQ_DEL, 8'h00, 8'hFF);
        send_req(leb_pkg::REQ_READ, 8'hFF, 8'h00);
        send_req(REQ_SPARE_A, 8'hFF, 8'hFF);
        send_req(REQ_SPARE_B, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_INSERT, 8'h00, 8'hFF);
        send_req(leb_pkg::REQ_INSERT, 8'hFF, 8'h00);
        send_req(leb_pkg::REQ_INSERT, 8'h80, 8'h55);
        send_req(leb_pkg::REQ_INSERT, 8'h7F, 8'hAA);
        send_req(leb_pkg::REQ_RIGHT, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_LEFT, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_LEFT, 8'h00, 8'h00);
        // insert in the middle shifts the tail
        send_req(leb_pkg::REQ_INSERT, 8'h5A, 8'h00);
        for (int i = 0; i < 5; i++)
            send_req(leb_pkg::REQ_READ, 8'h00, 8'(i));
        send_req(leb_pkg::REQ_READ, 8'h00, 8'hFF);
        send_req(leb_pkg::REQ_DEL, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_BKSPC, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_READ, 8'h00, 8'd1);
        drain_results();
    endtask

    // Fill to a full line, push against both ends, then erase to empty
    task automatic test_fill_and_erase();
        int roll;
        while (line_length < leb_pkg::LINE_MAX)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                send_req(leb_pkg::REQ_INSERT, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else if (roll < 80)
                send_req(leb_pkg::REQ_LEFT, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else if (roll < 90)
                send_req(leb_pkg::REQ_RIGHT, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else
                send_random(MIX_WANDER);
        end
        send_req(leb_pkg::REQ_INSERT, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_INSERT, 8'hFF, 8'hFF);
        send_req(leb_pkg::REQ_READ, 8'h00, 8'hFF);
        send_req(leb_pkg::REQ_READ, 8'hFF, 8'h00);
        while (cur_pos < line_length)
            send_req(leb_pkg::REQ_RIGHT, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        send_req(leb_pkg::REQ_RIGHT, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_DEL, 8'h00, 8'h00);
        while (line_length > 0)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                send_req(leb_pkg::REQ_BKSPC, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else if (roll < 80)
                send_req(leb_pkg::REQ_DEL, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else if (roll < 90)
                send_req(leb_pkg::REQ_LEFT, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            else
                send_random(MIX_WANDER);
        end
        send_req(leb_pkg::REQ_BKSPC, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_READ, 8'h00, 8'h00);
        drain_results();
    endtask

    // Random phases of growing, shrinking and wandering edits
    task automatic test_random_edits(input int count);
        int        sent;
        int        phase_len;
        edit_mix_t mix;
        sent = 0;
        while (sent < count)
        begin
            phase_len = $urandom_range(30, 80);
            mix = edit_mix_t'($urandom_range(2));
            if (line_length > 200)
                mix = MIX_SHRINK;
            else if (line_length < 20)
                mix = MIX_GROW;
            // one phase in six runs with no stalls on either side
            idle_en = ($urandom_range(5) != 0);
            for (int i = 0; i < phase_len; i++)
                send_random(mix);
            sent += phase_len;
        end
        idle_en = 1'b1;
        drain_results();
    endtask

    // Sink holds off long enough for the block to stall its input
    task automatic test_backpressure();
        rsp_hold = 600;
        for (int i = 0; i < 12; i++)
            send_random(MIX_GROW);
        drain_results();
    endtask

    // Sender pauses with nothing outstanding, then resumes
    task automatic test_sender_pause();
        for (int i = 0; i < 20; i++)
            send_random(MIX_WANDER);
        drain_results();
        repeat (40) @(posedge clk);
        for (int i = 0; i < 20; i++)
            send_random(MIX_SHRINK);
        drain_results();
    endtask

    // Insert/backspace pairs at the line end, back to back with no idling
    task automatic test_delete_pairs();
        idle_en = 1'b0;
        while (cur_pos < line_length)
            send_req(leb_pkg::REQ_RIGHT, 8'h00, 8'h00);
        for (int i = 0; i < 50; i++)
        begin
            send_req(leb_pkg::REQ_INSERT, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
            send_req(leb_pkg::REQ_BKSPC, 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        end
        send_req(leb_pkg::REQ_LEFT, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_DEL, 8'h00, 8'h00);
        send_req(leb_pkg::REQ_READ, 8'h00, 8'h00);
        drain_results();
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        err_count    = 0;
        idle_en      = 1'b1;
        rsp_hold     = 0;
        cur_pos      = 0;
        line_length  = 0;
        dirty_mark   = 1'b0;
        delete_cnt   = 0;
        foreach (line_img[i])
            line_img[i] = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_erase();
        test_random_edits(500);
        test_backpressure();
        test_sender_pause();
        test_delete_pairs();
        test_random_edits(150);

        drain_results();
        repeat (leb_pkg::LINE_MAX + 20) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
